// ----- src/emgab_pkg.sv -----
// ----------------------------------------------------------------------------
// emgab_pkg
// Shared types, constants and sample helpers for the EMG artifact blanker.
// ----------------------------------------------------------------------------
package emgab_pkg;

  localparam int unsigned MAX_SAMPLES_DEF  = 4096;
  localparam int unsigned BLANK_MARGIN_DEF = 10;

  // a nonzero sample after more than this many zero samples is killed
  localparam int unsigned IDLE_GAP = 250;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned THR_W    = 23;
  localparam int unsigned IDLE_W   = 16;
  localparam int unsigned RUN_W    = 13;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned CFG_W    = 23;

  localparam logic [THR_W-1:0]  HIGH_THRESHOLD_RST = 23'd1500;
  localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST   = 16'd1000;
  localparam logic [RUN_W-1:0]  MIN_RUN_LENGTH_RST = 13'd9;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SPIKE_ENABLE   = 2'd0,
    REG_HIGH_THRESHOLD = 2'd1,
    REG_IDLE_TIMEOUT   = 2'd2,
    REG_MIN_RUN_LENGTH = 2'd3
  } reg_idx_e;

  function automatic logic [SAMPLE_W-1:0] mag(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] u;
    u = s;
    return s[SAMPLE_W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic opposite(input logic signed [SAMPLE_W-1:0] a,
                                    input logic signed [SAMPLE_W-1:0] b);
    return (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction

  function automatic logic same_sign(input logic signed [SAMPLE_W-1:0] a,
                                     input logic signed [SAMPLE_W-1:0] b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

endpackage

// ----- src/emgab_store.sv -----
// ----------------------------------------------------------------------------
// emgab_store
// Sample store: signal and rms arrays, one write port with per-array enables,
// one read port with registered data.
// ----------------------------------------------------------------------------
module emgab_store #(
  parameter int unsigned DEPTH = emgab_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                                  clk_i,
  input  logic                                  we_sig_i,
  input  logic                                  we_rms_i,
  input  logic [AW-1:0]                         waddr_i,
  input  logic signed [emgab_pkg::SAMPLE_W-1:0] wsig_i,
  input  logic [emgab_pkg::SAMPLE_W-1:0]        wrms_i,
  input  logic [AW-1:0]                         raddr_i,
  output logic signed [emgab_pkg::SAMPLE_W-1:0] rsig_o,
  output logic [emgab_pkg::SAMPLE_W-1:0]        rrms_o
);

  logic signed [emgab_pkg::SAMPLE_W-1:0] sig_mem [DEPTH];
  logic [emgab_pkg::SAMPLE_W-1:0]        rms_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_sig_i) begin
      sig_mem[waddr_i] <= wsig_i;
    end
    if (we_rms_i) begin
      rms_mem[waddr_i] <= wrms_i;
    end
    rsig_o <= sig_mem[raddr_i];
    rrms_o <= rms_mem[raddr_i];
  end

endmodule

// ----- src/emg_artifact_blanker_top.sv -----
// ----------------------------------------------------------------------------
// emg_artifact_blanker_top
// EMG artifact blanker: block store, four in-place cleaning passes, readout.
// ----------------------------------------------------------------------------
// Load commands (tuser 0) are taken one per cycle while the output is not
// stalled and append a sample to the store; a full store drops the sample.
// A run command (tuser 1) walks the store with one read port and one write
// port: every visited sample is read, then decided and written back, and a
// blanking or run sweep zeroes its span in a further walk. A run answers
// with one transfer carrying the sample count. A read command (tuser 2)
// returns the next cleaned sample through the store's registered read and
// the RD state; tlast marks the final sample.
// Reads past the end and command 3 give no transfer.
// ----------------------------------------------------------------------------
module emg_artifact_blanker_top #(
  parameter int unsigned MAX_SAMPLES  = emgab_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned BLANK_MARGIN = emgab_pkg::BLANK_MARGIN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [47:0]                  s_axis_tdata,  // signal_in, rms_in
  input  logic [1:0]                   s_axis_tuser,  // command
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [63:0]                  m_axis_tdata,  // signal_out, rms_out, sample_count
  output logic                         m_axis_tlast,  // last_sample
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [emgab_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned XW = CW + 8;
  localparam int unsigned SW = emgab_pkg::SAMPLE_W;

  typedef enum logic [4:0] {
    IDLE, RD,
    P1_A, P1_B, P1_C, P1_D, P1_E,
    P2_Z, P2_R0, P2_PH, P2_RI, P2_E, P2_SW,
    P3_S, P3_RI, P3_E,
    P4_S, P4_R0, P4_PV, P4_RI, P4_E, P4_SW,
    DONE
  } state_e;

  state_e state_q;

  logic                                spike_en_q;
  logic [emgab_pkg::THR_W-1:0]         thr_q;
  logic [emgab_pkg::IDLE_W-1:0]        idle_to_q;
  logic [emgab_pkg::RUN_W-1:0]         mrl_q;

  logic [CW-1:0] n_q, rp_q, i_q, j_q, stop_q, start_q, count_q;
  logic signed [SW-1:0] prev_q, cur_q;
  logic          prevhi_q;
  logic [7:0]    idle_q;
  logic [emgab_pkg::IDLE_W-2:0] kill_q;

  logic                 m_valid_q, last_q;
  logic signed [SW-1:0] sig_o_q;
  logic [SW-1:0]        rms_o_q;
  logic [emgab_pkg::COUNT_W-1:0] cnt_o_q;

  logic                 we_sig, we_rms;
  logic [AW-1:0]        waddr, raddr;
  logic signed [SW-1:0] wsig, rsig;
  logic [SW-1:0]        wrms, rrms;

  logic s_fire;
  emgab_pkg::cmd_e cmd;
  logic spike_hit, hi_rd, rd_zero, p3_trig, p2_more, p2_first, run_long;
  logic [XW-1:0] stop_x;

  assign cmd           = emgab_pkg::cmd_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == IDLE) && (!m_valid_q || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {3'b000, cnt_o_q, rms_o_q, sig_o_q};

  assign spike_hit = emgab_pkg::opposite(prev_q, cur_q) && emgab_pkg::opposite(rsig, cur_q);
  assign hi_rd     = emgab_pkg::mag(rsig) > SW'(thr_q);
  assign rd_zero   = (rsig == '0) && (rrms == '0);
  assign p3_trig   = (kill_q == '0) && !rd_zero && (idle_q > 8'(emgab_pkg::IDLE_GAP));
  // next index i+1 still inside the blanking scan
  assign p2_more   = (XW'(i_q) + XW'(BLANK_MARGIN) + XW'(2)) < XW'(n_q);
  assign p2_first  = (XW'(2 * BLANK_MARGIN + 2)) < XW'(n_q);
  assign stop_x    = ((XW'(i_q) + XW'(BLANK_MARGIN)) > XW'(n_q)) ? XW'(n_q)
                                                               : XW'(i_q) + XW'(BLANK_MARGIN);
  assign run_long  = (XW'(count_q) > XW'(mrl_q));

  always_comb begin
    raddr  = '0;
    waddr  = '0;
    we_sig = 1'b0;
    we_rms = 1'b0;
    wsig   = '0;
    wrms   = '0;
    unique case (state_q)
      IDLE: begin
        if (s_fire && cmd == emgab_pkg::CMD_LOAD && XW'(n_q) < XW'(MAX_SAMPLES)) begin
          we_sig = 1'b1;
          we_rms = 1'b1;
          waddr  = n_q[AW-1:0];
          wsig   = s_axis_tdata[23:0];
          wrms   = s_axis_tdata[47:24];
        end
        raddr = rp_q[AW-1:0];
      end
      P1_A:  raddr = '0;
      P1_B:  raddr = AW'(1);
      P1_D:  raddr = AW'(i_q + 1'b1);
      P1_E: begin
        if (spike_hit) begin
          we_sig = 1'b1;
          we_rms = 1'b1;
          waddr  = i_q[AW-1:0];
        end
      end
      P2_Z: begin
        we_sig = 1'b1;
        waddr  = '0;
      end
      P2_R0: raddr = AW'(BLANK_MARGIN);
      P2_RI: raddr = i_q[AW-1:0];
      P2_SW: begin
        if (j_q < stop_q) begin
          we_sig = 1'b1;
          we_rms = 1'b1;
          waddr  = j_q[AW-1:0];
        end
      end
      P3_RI: raddr = i_q[AW-1:0];
      P3_E: begin
        if (kill_q != '0 || p3_trig) begin
          we_sig = 1'b1;
          we_rms = 1'b1;
          waddr  = i_q[AW-1:0];
        end
      end
      P4_R0: raddr = '0;
      P4_RI: raddr = i_q[AW-1:0];
      P4_SW: begin
        if (j_q < stop_q) begin
          we_sig = 1'b1;
          we_rms = 1'b1;
          waddr  = j_q[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  emgab_store #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk_i    (clk_i),
    .we_sig_i (we_sig),
    .we_rms_i (we_rms),
    .waddr_i  (waddr),
    .wsig_i   (wsig),
    .wrms_i   (wrms),
    .raddr_i  (raddr),
    .rsig_o   (rsig),
    .rrms_o   (rrms)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spike_en_q <= 1'b0;
      thr_q      <= emgab_pkg::HIGH_THRESHOLD_RST;
      idle_to_q  <= emgab_pkg::IDLE_TIMEOUT_RST;
      mrl_q      <= emgab_pkg::MIN_RUN_LENGTH_RST;
    end else if (cfg_valid_i) begin
      unique case (emgab_pkg::reg_idx_e'(cfg_index_i))
        emgab_pkg::REG_SPIKE_ENABLE:   spike_en_q <= cfg_data_i[0];
        emgab_pkg::REG_HIGH_THRESHOLD: thr_q      <= cfg_data_i[22:0];
        emgab_pkg::REG_IDLE_TIMEOUT:   idle_to_q  <= cfg_data_i[15:0];
        emgab_pkg::REG_MIN_RUN_LENGTH: mrl_q      <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      n_q       <= '0;
      rp_q      <= '0;
      m_valid_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      stop_q    <= '0;
      start_q   <= '0;
      count_q   <= '0;
      prevhi_q  <= 1'b0;
      idle_q    <= '0;
      kill_q    <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (s_fire) begin
            case (cmd)
              emgab_pkg::CMD_LOAD: begin
                if (XW'(n_q) < XW'(MAX_SAMPLES)) begin
                  n_q <= n_q + 1'b1;
                end
              end
              emgab_pkg::CMD_RUN: begin
                if (n_q == '0) begin
                  state_q <= DONE;
                end else if (spike_en_q && n_q >= CW'(3)) begin
                  state_q <= P1_A;
                end else begin
                  state_q <= P2_Z;
                end
              end
              emgab_pkg::CMD_READ: begin
                if (rp_q < n_q) begin
                  state_q <= RD;
                end
              end
              default: ;
            endcase
          end
        end
        RD: begin
          sig_o_q   <= rsig;
          rms_o_q   <= rrms;
          last_q    <= (rp_q + 1'b1) == n_q;
          cnt_o_q   <= '0;
          m_valid_q <= 1'b1;
          rp_q      <= rp_q + 1'b1;
          state_q   <= IDLE;
        end
        P1_A: state_q <= P1_B;
        P1_B: begin
          prev_q  <= rsig;
          state_q <= P1_C;
        end
        P1_C: begin
          cur_q   <= rsig;
          i_q     <= CW'(1);
          state_q <= P1_D;
        end
        P1_D: state_q <= P1_E;
        P1_E: begin
          prev_q  <= spike_hit ? '0 : cur_q;
          cur_q   <= rsig;
          i_q     <= i_q + 1'b1;
          state_q <= ((XW'(i_q) + XW'(3)) < XW'(n_q)) ? P1_D : P2_Z;
        end
        P2_Z: begin
          start_q <= '0;
          state_q <= p2_first ? P2_R0 : P3_S;
        end
        P2_R0: begin
          i_q     <= CW'(BLANK_MARGIN + 1);
          state_q <= P2_PH;
        end
        P2_PH: begin
          prevhi_q <= hi_rd;
          state_q  <= P2_RI;
        end
        P2_RI: state_q <= P2_E;
        P2_E: begin
          if (hi_rd && !prevhi_q) begin
            start_q <= i_q - CW'(BLANK_MARGIN);
          end
          if (!hi_rd && prevhi_q) begin
            stop_q  <= CW'(stop_x);
            j_q     <= start_q;
            state_q <= P2_SW;
          end else begin
            prevhi_q <= hi_rd;
            i_q      <= i_q + 1'b1;
            state_q  <= p2_more ? P2_RI : P3_S;
          end
        end
        P2_SW: begin
          if (j_q < stop_q) begin
            j_q <= j_q + 1'b1;
          end else begin
            // sample i lies inside the blanked span
            prevhi_q <= 1'b0;
            i_q      <= i_q + 1'b1;
            state_q  <= p2_more ? P2_RI : P3_S;
          end
        end
        P3_S: begin
          i_q     <= '0;
          idle_q  <= '0;
          kill_q  <= '0;
          state_q <= P3_RI;
        end
        P3_RI: state_q <= P3_E;
        P3_E: begin
          if (kill_q != '0) begin
            kill_q <= kill_q - 1'b1;
          end else if (rd_zero) begin
            if (idle_q <= 8'(emgab_pkg::IDLE_GAP)) begin
              idle_q <= idle_q + 1'b1;
            end
          end else begin
            if (p3_trig) begin
              kill_q <= idle_to_q[emgab_pkg::IDLE_W-1:1];
            end
            idle_q <= '0;
          end
          i_q     <= i_q + 1'b1;
          state_q <= ((XW'(i_q) + XW'(1)) < XW'(n_q)) ? P3_RI : P4_S;
        end
        P4_S: begin
          i_q     <= CW'(1);
          count_q <= '0;
          state_q <= (n_q < CW'(2)) ? DONE : P4_R0;
        end
        P4_R0: state_q <= P4_PV;
        P4_PV: begin
          prev_q  <= rsig;
          state_q <= P4_RI;
        end
        P4_RI: state_q <= P4_E;
        P4_E: begin
          prev_q <= rsig;
          i_q    <= i_q + 1'b1;
          if (emgab_pkg::same_sign(rsig, prev_q)) begin
            count_q <= count_q + 1'b1;
            state_q <= ((XW'(i_q) + XW'(1)) < XW'(n_q)) ? P4_RI : DONE;
          end else begin
            count_q <= '0;
            if (run_long) begin
              j_q     <= i_q - count_q;
              stop_q  <= i_q;
              state_q <= P4_SW;
            end else begin
              state_q <= ((XW'(i_q) + XW'(1)) < XW'(n_q)) ? P4_RI : DONE;
            end
          end
        end
        P4_SW: begin
          if (j_q < stop_q) begin
            j_q <= j_q + 1'b1;
          end else begin
            state_q <= (i_q < n_q) ? P4_RI : DONE;
          end
        end
        DONE: begin
          sig_o_q   <= '0;
          rms_o_q   <= '0;
          last_q    <= 1'b0;
          cnt_o_q   <= emgab_pkg::COUNT_W'(n_q);
          m_valid_q <= 1'b1;
          rp_q      <= '0;
          state_q   <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(n_q) <= XW'(MAX_SAMPLES))
    else $error("loaded count beyond capacity");

  a_rp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= n_q)
    else $error("read pointer beyond loaded count");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != IDLE) |-> !s_axis_tready)
    else $error("input accepted while passes run");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == RD || $past(state_q) == DONE))
    else $error("result raised outside read or run completion");
`endif

endmodule
